FILE: sv/suv_pkg.sv
// Shared types and constants for the strict UTF-8 validator.
`timescale 1ns / 1ps

package suv_pkg;

    // Code point limits and boundaries
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_LEN1  = 21'h000080;
    localparam logic [20:0] CP_MIN_LEN2  = 21'h000800;
    localparam logic [20:0] CP_MIN_LEN3  = 21'h010000;
    localparam logic [20:0] CP_CTRL_LIM  = 21'h000020;
    localparam logic [20:0] CP_DEL       = 21'h00007F;
    localparam logic [20:0] CP_C1_HI     = 21'h00009F;
    localparam logic [20:0] CP_LF        = 21'h00000A;
    localparam logic [20:0] CP_TAB       = 21'h000009;

    // Continuation counts for each sequence length
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]  pend;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic        failed;
    } t_state;

endpackage

FILE: sv/suv_in_if.sv
// Input channel of the validator: one byte transaction per handshake.
`timescale 1ns / 1ps

interface suv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, output data_byte, output byte_present,
                     output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                     input end_of_string, output ready);
endinterface

FILE: sv/suv_out_if.sv
// Output channel of the validator: one verdict transaction per string.
`timescale 1ns / 1ps

interface suv_out_if;
    logic valid;
    logic ready;
    logic string_valid;

    modport source (output valid, output string_valid, input ready);
    modport sink   (input valid, input string_valid, output ready);
endinterface

FILE: sv/suv_step.sv
// Per-byte decode step: next decoder state and end-of-string verdict.
`timescale 1ns / 1ps

module suv_step (
    input  suv_pkg::t_state i_state,
    input  logic [7:0]      i_data_byte,
    input  logic            i_byte_present,
    input  logic            i_end_of_string,
    output suv_pkg::t_state o_state_next,
    output logic            o_verdict
);
    import suv_pkg::*;

    t_state      s;
    logic [20:0] acc_next;
    logic [1:0]  pend_next;
    logic [20:0] lead_cp;
    logic        bad_ctrl_lead;
    logic        bad_ctrl_cp;
    logic        bad_cp;

    // Shift in six payload bits of a continuation byte
    assign acc_next  = {i_state.acc[14:0], i_data_byte[5:0]};
    assign pend_next = i_state.pend - 2'd1;
    assign lead_cp   = {13'd0, i_data_byte};

    // Reject control characters other than newline and tab, and DEL to C1
    assign bad_ctrl_lead = ((lead_cp < CP_CTRL_LIM) && (lead_cp != CP_LF)
                            && (lead_cp != CP_TAB))
                           || (lead_cp == CP_DEL);
    assign bad_ctrl_cp   = ((acc_next < CP_CTRL_LIM) && (acc_next != CP_LF)
                            && (acc_next != CP_TAB))
                           || ((acc_next >= CP_DEL) && (acc_next <= CP_C1_HI));

    // Check a completed code point for overlong, range, surrogate and control faults
    always_comb begin
        bad_cp = bad_ctrl_cp || (acc_next > CP_MAX)
                 || ((acc_next >= CP_SURR_LO) && (acc_next <= CP_SURR_HI));
        unique case (i_state.seq_len)
            SEQ_TWO:   if (acc_next < CP_MIN_LEN1) bad_cp = 1'b1;
            SEQ_THREE: if (acc_next < CP_MIN_LEN2) bad_cp = 1'b1;
            SEQ_FOUR:  if (acc_next < CP_MIN_LEN3) bad_cp = 1'b1;
            default:   ;
        endcase
    end

    // Advance the decoder by one byte, then close the string if asked
    always_comb begin
        s = i_state;
        if (i_byte_present && !i_state.failed) begin
            if (i_state.pend == SEQ_NONE) begin
                if (!i_data_byte[7]) begin
                    if (bad_ctrl_lead) begin
                        s        = '0;
                        s.failed = 1'b1;
                    end
                end else if (i_data_byte[7:5] == 3'b110) begin
                    if (i_data_byte[4:0] == 5'd0) begin
                        s        = '0;
                        s.failed = 1'b1;
                    end else begin
                        s.acc     = {16'd0, i_data_byte[4:0]};
                        s.seq_len = SEQ_TWO;
                        s.pend    = SEQ_TWO;
                    end
                end else if (i_data_byte[7:4] == 4'b1110) begin
                    s.acc     = {17'd0, i_data_byte[3:0]};
                    s.seq_len = SEQ_THREE;
                    s.pend    = SEQ_THREE;
                end else if (i_data_byte[7:3] == 5'b11110) begin
                    s.acc     = {18'd0, i_data_byte[2:0]};
                    s.seq_len = SEQ_FOUR;
                    s.pend    = SEQ_FOUR;
                end else begin
                    s        = '0;
                    s.failed = 1'b1;
                end
            end else if (i_data_byte[7:6] != 2'b10) begin
                s        = '0;
                s.failed = 1'b1;
            end else if (pend_next != SEQ_NONE) begin
                s.acc  = acc_next;
                s.pend = pend_next;
            end else if (bad_cp) begin
                s        = '0;
                s.failed = 1'b1;
            end else begin
                s = '0;
            end
        end
        o_verdict    = !s.failed && (s.pend == SEQ_NONE);
        o_state_next = i_end_of_string ? t_state'('0) : s;
    end

endmodule

FILE: sv/strict_utf8_validator.sv
// Top level of the strict UTF-8 validator: input register, decoder, verdict register.
// A verdict is registered: the closing transaction passes the input register, then the
// verdict register, waiting in the input register while an earlier verdict is held.
// Throughput: one byte transaction per cycle, except while a closing transaction waits
// on a held verdict; set by the update of the decoder state register from the input register.
// Reset (synchronous, active low) empties both registers and clears the decoder state.
`timescale 1ns / 1ps

module strict_utf8_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    suv_in_if.sink    i_in,
    suv_out_if.source o_out
);
    import suv_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_present;
    logic       r_s1_eos;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic       r_out_sv;
    logic       n_verdict;
    logic       s1_fire;

    // Decode the held byte against the current state
    suv_step u_step (
        .i_state         (r_state),
        .i_data_byte     (r_s1_byte),
        .i_byte_present  (r_s1_present),
        .i_end_of_string (r_s1_eos),
        .o_state_next    (n_state),
        .o_verdict       (n_verdict)
    );

    // Retire the held transaction unless its verdict cannot be stored
    assign s1_fire = r_s1_valid && (!r_s1_eos || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;

    // Hold the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_s1_byte    <= i_in.data_byte;
            r_s1_present <= i_in.byte_present;
            r_s1_eos     <= i_in.end_of_string;
        end
    end

    // Advance the decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // Hold the verdict until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_eos) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_s1_eos) begin
            r_out_sv <= n_verdict;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.string_valid = r_out_sv;

    // A closing transaction always leaves a verdict behind
    a_verdict_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_eos |=> r_out_valid)
        else $error("closing transaction produced no verdict");

    // A failed string expects no more continuations
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.failed |-> (r_state.pend == SEQ_NONE))
        else $error("continuations pending after failure");

    // Pending count never exceeds the sequence length
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pend <= r_state.seq_len)
        else $error("pending count beyond sequence length");

    // Between sequences the accumulator and length are clear
    a_clear_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pend == SEQ_NONE) |-> (r_state.seq_len == SEQ_NONE
                                        && r_state.acc == 21'd0))
        else $error("stale sequence state between code points");

    // A stalled verdict is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_sv))
        else $error("pending verdict lost");

endmodule

FILE: tb/sv/strict_utf8_validator_tb.sv
// Self-checking testbench for the strict UTF-8 validator with directed and random byte strings.
`timescale 1ns / 1ps

module strict_utf8_validator_tb;

    import suv_pkg::*;

    // Lead and continuation byte patterns
    localparam logic [7:0] ASCII_LIM  = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_AT      = 400;
    localparam int DRAIN_AT     = 800;
    localparam int STEADY_FROM  = 1000;
    localparam int STEADY_TO    = 1300;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 29;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 40;

    // Decoder model and queue of verdicts still owed by the block
    class utf8_scoreboard;
        logic [1:0]  pend_cont;
        logic [1:0]  seq_len;
        logic [20:0] code_acc;
        logic        failed;
        logic        verdict_q[$];
        int          mismatches;

        function new();
            clear_string();
            mismatches = 0;
        endfunction

        function void clear_string();
            pend_cont = SEQ_NONE;
            seq_len   = SEQ_NONE;
            code_acc  = '0;
            failed    = 1'b0;
        endfunction

        function void mark_failed();
            clear_string();
            failed = 1'b1;
        endfunction

        function bit is_bad_control(logic [20:0] cp);
            if (cp < CP_CTRL_LIM && cp != CP_LF && cp != CP_TAB) begin
                return 1'b1;
            end
            return cp >= CP_DEL && cp <= CP_C1_HI;
        endfunction

        // Overlong forms, out-of-range values, surrogates and banned controls
        function bit is_bad_code(logic [20:0] cp, logic [1:0] len);
            if (len == SEQ_TWO && cp < CP_MIN_LEN1) return 1'b1;
            if (len == SEQ_THREE && cp < CP_MIN_LEN2) return 1'b1;
            if (len == SEQ_FOUR && cp < CP_MIN_LEN3) return 1'b1;
            if (cp > CP_MAX) return 1'b1;
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) return 1'b1;
            return is_bad_control(cp);
        endfunction

        function void absorb_byte(logic [7:0] b);
            if (failed) return;
            // Expect a lead byte or plain ASCII
            if (pend_cont == SEQ_NONE) begin
                if (b < ASCII_LIM) begin
                    if (is_bad_control({13'd0, b})) mark_failed();
                    return;
                end
                if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                    code_acc = {16'd0, b[4:0]};
                    if (code_acc == '0) begin
                        mark_failed();
                        return;
                    end
                    seq_len = SEQ_TWO;
                end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                    code_acc = {17'd0, b[3:0]};
                    seq_len  = SEQ_THREE;
                end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                    code_acc = {18'd0, b[2:0]};
                    seq_len  = SEQ_FOUR;
                end else begin
                    mark_failed();
                    return;
                end
                pend_cont = seq_len;
                return;
            end
            // Continuation byte: accumulate and check on completion
            if ((b & CONT_MASK) != CONT_TAG) begin
                mark_failed();
                return;
            end
            code_acc  = {code_acc[14:0], b[5:0]};
            pend_cont = pend_cont - 2'd1;
            if (pend_cont == SEQ_NONE) begin
                if (is_bad_code(code_acc, seq_len)) begin
                    mark_failed();
                    return;
                end
                seq_len  = SEQ_NONE;
                code_acc = '0;
            end
        endfunction

        function void note_input(logic [7:0] b, logic present, logic eos);
            if (present) absorb_byte(b);
            if (eos) begin
                verdict_q.insert(verdict_q.size(), !failed && pend_cont == SEQ_NONE);
                clear_string();
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
        endtask

        task check_verdict(logic got);
            logic want;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with no string closed", got));
                return;
            end
            want = verdict_q.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("string_valid %0b, expected %0b", got, want));
            end
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    suv_in_if        in_ch();
    suv_out_if       out_ch();
    utf8_scoreboard  sb;
    logic [7:0]      str_bytes[$];
    int              items_sent = 0;
    int              hold_left = 0;
    int              stall_cycles = 0;
    bit              idling_on = 1'b1;
    bit              hold_request = 1'b0;

    strict_utf8_validator DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive ready: long hold-off on request, otherwise random stalls
    always @(negedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = !(idling_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Check each verdict transaction
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) sb.check_verdict(out_ch.string_valid);
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Append one byte to the string being built
    function automatic void append_byte(logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic eos);
        @(negedge clk);
        while (idling_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.data_byte     = b;
        in_ch.byte_present  = present;
        in_ch.end_of_string = eos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(b, present, eos);
        if (present || eos) items_sent++;
    endtask

    task automatic park_input();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_for_verdicts();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Send the queued bytes as one string, closed by its last byte or an empty close
    task automatic send_string(input bit empty_close);
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 4) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(str_bytes[i], 1'b1, !empty_close && i == n - 1);
        end
        if (empty_close || n == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        str_bytes.delete();
    endtask

    // Encode a code point in a forced length, overlong forms included
    function automatic void push_code(logic [20:0] cp, int len);
        case (len)
            1: append_byte({1'b0, cp[6:0]});
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic int natural_len(logic [20:0] cp);
        if (cp < CP_MIN_LEN1) return 1;
        if (cp < CP_MIN_LEN2) return 2;
        if (cp < CP_MIN_LEN3) return 3;
        return 4;
    endfunction

    function automatic logic [20:0] boundary_cp(int idx);
        case (idx)
            0:  return 21'h000000;
            1:  return 21'h000008;
            2:  return CP_TAB;
            3:  return CP_LF;
            4:  return 21'h00000B;
            5:  return 21'h00001F;
            6:  return CP_CTRL_LIM;
            7:  return 21'h00007E;
            8:  return CP_DEL;
            9:  return CP_MIN_LEN1;
            10: return CP_C1_HI;
            11: return 21'h0000A0;
            12: return 21'h0007FF;
            13: return CP_MIN_LEN2;
            14: return 21'h00D7FF;
            15: return CP_SURR_LO;
            16: return CP_SURR_HI;
            17: return 21'h00E000;
            18: return 21'h00FFFF;
            19: return CP_MIN_LEN3;
            20: return CP_MAX;
            21: return 21'h110000;
            default: return 21'h1FFFFF;
        endcase
    endfunction

    // Append one character: mostly well formed, sometimes broken
    task automatic add_char();
        int          kind;
        int          len;
        logic [20:0] cp;
        kind = $urandom_range(99);
        if (kind < 40) begin
            len = 1;
            if ($urandom_range(19) == 0) cp = $urandom_range(1) ? CP_LF : CP_TAB;
            else cp = 21'($urandom_range(32'h7E, 32'h20));
        end else if (kind < 60) begin
            len = 2;
            cp  = 21'($urandom_range(32'h7FF, 32'hA0));
        end else if (kind < 75) begin
            len = 3;
            cp  = 21'($urandom_range(32'hFFFF, 32'h800));
            // move surrogates out of the way
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp[12] = 1'b0;
        end else if (kind < 87) begin
            len = 4;
            cp  = 21'($urandom_range(32'h10FFFF, 32'h10000));
        end else if (kind < 91) begin
            cp  = boundary_cp($urandom_range(22));
            len = natural_len(cp);
            if (len < 4 && $urandom_range(2) == 0) len++;
        end else if (kind < 95) begin
            append_byte(8'($urandom_range(255)));
            return;
        end else if (kind < 98) begin
            // truncated multibyte sequence
            len = $urandom_range(4, 2);
            if (len == 2) cp = 21'($urandom_range(32'h7FF, 32'hA0));
            else if (len == 3) cp = 21'($urandom_range(32'hFFFF, 32'hE000));
            else cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
            push_code(cp, len);
            str_bytes.pop_back();
            if (len > 2 && $urandom_range(1)) str_bytes.pop_back();
            return;
        end else begin
            cp  = $urandom_range(1) ? 21'($urandom_range(31))
                                    : 21'($urandom_range(32'h9F, 32'h7F));
            len = natural_len(cp);
        end
        push_code(cp, len);
    endtask

    initial begin
        bit hold_done;
        bit drain_done;
        hold_done            = 1'b0;
        drain_done           = 1'b0;
        sb                   = new();
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.byte_present   = 1'b0;
        in_ch.end_of_string  = 1'b0;
        out_ch.ready         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings
        send_item(8'h00, 1'b0, 1'b1);           // empty string
        send_item(8'h0A, 1'b1, 1'b0);           // newline, idle item, tab
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h09, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);           // NUL control
        send_item(8'h7F, 1'b1, 1'b1);           // DEL
        str_bytes = '{8'hC2, 8'h80};            // decoded C1 control
        send_string(1'b0);
        send_item(8'hC0, 1'b1, 1'b1);           // forbidden lead
        str_bytes = '{8'hE0, 8'h80, 8'h80};     // overlong three-byte form
        send_string(1'b0);
        str_bytes = '{8'hED, 8'hA0, 8'h80};     // surrogate
        send_string(1'b0);
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};  // above the code point limit
        send_string(1'b0);
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};  // highest code point
        send_string(1'b0);
        str_bytes = '{8'hE2, 8'h82};            // cut off at the end
        send_string(1'b0);
        send_item(8'hFF, 1'b1, 1'b1);           // invalid lead

        // Random strings with one long receiver hold-off and one full drain
        while (items_sent < RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && items_sent >= DRAIN_AT) begin
                park_input();
                wait_for_verdicts();
                drain_done = 1'b1;
            end
            idling_on = !(items_sent >= STEADY_FROM && items_sent < STEADY_TO);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(6)) add_char();
            end
            send_string($urandom_range(4) == 0);
        end

        // Drain and settle
        park_input();
        wait_for_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: strict_utf8_validator.f
sv/suv_pkg.sv
sv/suv_in_if.sv
sv/suv_out_if.sv
sv/suv_step.sv
sv/strict_utf8_validator.sv
tb/sv/strict_utf8_validator_tb.sv
